>>> sv/rlfe_pkg.sv
package rlfe_pkg;

	// Field widths fixed by the frame format
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned RGB_W   = 3 * COLOR_W;
	localparam int unsigned WORD_W  = 32;

	localparam logic [CNT_W-1:0] LED_COUNT_RESET = 6'd32;

	// Item modes
	localparam logic MODE_SET     = 1'b0;
	localparam logic MODE_REFRESH = 1'b1;

	// Flag byte: two fixed ones, then the inverted top bits of blue, green, red
	localparam logic [7:0] FLAG_BASE  = 8'hFF;
	localparam logic [7:0] FLAG_BLUE  = 8'h30;
	localparam logic [7:0] FLAG_GREEN = 8'h0C;
	localparam logic [7:0] FLAG_RED   = 8'h03;
	localparam logic [WORD_W-1:0] ZERO_WORD = '0;

	typedef struct packed {
		logic               mode;
		logic [IDX_W-1:0]   start_index;
		logic [IDX_W-1:0]   end_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] frame_word;
		logic              last;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic take;       // latch the accepted item
		logic fill_wr;    // write one entry of the range, step index
		logic emit_zero;  // load the start word
		logic emit_led;   // load one LED word, step index
		logic emit_last;  // load the closing word
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic refresh;     // offered item is a refresh
		logic fill_empty;  // offered set item writes nothing
		logic fill_last;   // current entry closes the range
		logic led_none;    // LED count is zero
		logic led_last;    // current LED is the last one
		logic slot_free;   // output register can take a beat
	} dp_status_t;

	// Store layout: red 23:16, green 15:8, blue 7:0
	function automatic logic [WORD_W-1:0] led_word(input logic [RGB_W-1:0] rgb);
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		logic [7:0]         flag;
		r    = rgb[23:16];
		g    = rgb[15:8];
		b    = rgb[7:0];
		flag = FLAG_BASE
		     ^ ({2'b00, b[7:2]} & FLAG_BLUE)
		     ^ ({4'b0000, g[7:4]} & FLAG_GREEN)
		     ^ ({6'b000000, r[7:6]} & FLAG_RED);
		return {flag, b, g, r};
	endfunction

endpackage

>>> sv/rgb_led_chain_frame_encoder.sv
// Frame encoder for a chain of two-wire RGB LEDs. A set item (mode 0) writes
// one colour to LEDs start_index..end_index, clipped to the LED count; it
// gives no output and keeps the block busy while it writes the entries of
// the range (none for an empty range) after acceptance. A refresh item
// (mode 1) sends led_count + 2 beats: a zero start word, one flag/blue/
// green/red word per LED from index 0, and a zero end word with last set.
// With the sink ready a refresh sends one word per cycle, set by the single
// read port of the colour store and the single output register; out_ready
// low stalls it. Items are handled one at a time. The colour store powers
// up black through per-entry written marks cleared by reset, so there is no
// clearing pass. led_count is to be written on the cfg port (always ready)
// only while the block is idle; the block does not enforce this. Values
// above MAX_LEDS act as MAX_LEDS, and zero sends only the two framing words.
module rgb_led_chain_frame_encoder #(
	parameter int unsigned MAX_LEDS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rlfe_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rlfe_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rlfe_pkg::CNT_W-1:0] cfg_data
);
	import rlfe_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	rlfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rlfe_dp #(
		.MAX_LEDS (MAX_LEDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

>>> sv/rlfe_ram.sv
module rlfe_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> sv/rlfe_ctrl.sv
module rlfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rlfe_pkg::dp_status_t st,
	output rlfe_pkg::ctrl_cmd_t  cmd
);
	import rlfe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_START,
		S_WORD,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (st.refresh) begin
						state_d = S_START;
					end else if (!st.fill_empty) begin
						state_d = S_FILL;
					end
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (st.fill_last) begin
					state_d = S_IDLE;
				end
			end
			S_START: begin
				if (st.slot_free) begin
					cmd.emit_zero = 1'b1;
					state_d = st.led_none ? S_FINISH : S_WORD;
				end
			end
			S_WORD: begin
				if (st.slot_free) begin
					cmd.emit_led = 1'b1;
					if (st.led_last) begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (st.slot_free) begin
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/rlfe_dp.sv
module rlfe_dp #(
	parameter int unsigned MAX_LEDS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rlfe_pkg::in_item_t    in_data,
	input  logic                  cfg_valid,
	input  logic [rlfe_pkg::CNT_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output rlfe_pkg::out_item_t   out_data,
	input  rlfe_pkg::ctrl_cmd_t   cmd,
	output rlfe_pkg::dp_status_t  st
);
	import rlfe_pkg::*;

	localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEDS);

	logic [CNT_W-1:0]   led_count_q;
	logic [CNT_W-1:0]   cnt;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   idx_inc;
	logic [CNT_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   end_q;
	logic [RGB_W-1:0]   rgb_q;
	logic [RGB_W-1:0]   rd_rgb;
	logic [MAX_LEDS-1:0] vld_q;
	logic               vld_rd_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// Count register, saturated to the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_COUNT_RESET;
		end else if (cfg_valid) begin
			led_count_q <= cfg_data;
		end
	end

	assign cnt     = (led_count_q > MAX_CNT) ? MAX_CNT : led_count_q;
	assign idx_inc = idx_q + CNT_W'(1);

	// Item latch and walking index
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q <= (in_data.mode == MODE_REFRESH) ? '0 : {1'b0, in_data.start_index};
			end_q <= in_data.end_index;
			rgb_q <= {in_data.red, in_data.green, in_data.blue};
		end else if (cmd.fill_wr || cmd.emit_led) begin
			idx_q <= idx_inc;
		end
	end

	// Read one ahead while a LED word leaves, so the data is always current
	assign rd_idx = cmd.emit_led ? idx_inc : idx_q;

	rlfe_ram #(
		.WIDTH (RGB_W),
		.DEPTH (MAX_LEDS)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.fill_wr),
		.wr_addr (idx_q[AW-1:0]),
		.wr_data (rgb_q),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_data (rd_rgb)
	);

	// Per-entry written marks; an unwritten entry reads as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.fill_wr) begin
				vld_q[idx_q[AW-1:0]] <= 1'b1;
			end
			vld_rd_q <= (rd_idx < MAX_CNT) ? vld_q[rd_idx[AW-1:0]] : 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_zero || cmd.emit_led || cmd.emit_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_zero || cmd.emit_led || cmd.emit_last) begin
			out_q.frame_word <= cmd.emit_led ? led_word(vld_rd_q ? rd_rgb : '0) : ZERO_WORD;
			out_q.last       <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status
	assign st.refresh    = (in_data.mode == MODE_REFRESH);
	assign st.fill_empty = (in_data.end_index < in_data.start_index)
	                    || ({1'b0, in_data.start_index} >= cnt);
	assign st.fill_last  = (idx_q[IDX_W-1:0] == end_q) || (idx_inc >= cnt);
	assign st.led_none   = (cnt == '0);
	assign st.led_last   = (idx_inc == cnt);
	assign st.slot_free  = !out_valid_q || out_ready;

endmodule

>>> sv/rlfe_checker.sv
module rlfe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input rlfe_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input rlfe_pkg::out_item_t out_data
);
	import rlfe_pkg::*;

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// The closing beat is a zero word
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.frame_word == ZERO_WORD)
		else $error("last beat carries a non-zero word");

	// A refresh closes the input once it is accepted
	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.mode == MODE_REFRESH |=> !in_ready)
		else $error("input taken during a refresh");

	// Accepting a set item does not raise out_valid
	a_set_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.mode == MODE_SET |=> !$rose(out_valid))
		else $error("output beat after a set item");

endmodule

bind rgb_led_chain_frame_encoder rlfe_checker u_rlfe_checker (.*);
